// ----- design/assert_macros.svh -----
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off during reset
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, held off during reset
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/tmtf_pkg.sv -----
// Types and constants for the threshold move-to-front cache
package tmtf_pkg;

    localparam int CNT_W     = 16;
    localparam int LIMIT_W   = 5;
    localparam int OCC_OUT_W = 5;
    localparam int CFG_W     = 16;
    localparam logic [CNT_W-1:0] CNT_MAX = '1;
    localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

    typedef enum logic {
        FUNC_ACCESS = 1'b0,
        FUNC_CLEAR  = 1'b1
    } func_t;

    typedef enum logic {
        CFG_LENGTH_LIMIT    = 1'b0,
        CFG_COUNT_THRESHOLD = 1'b1
    } cfg_index_t;

    typedef struct packed {
        func_t       func;
        logic [31:0] address_key;
    } cmd_t;

    typedef struct packed {
        logic                 hit;
        logic [CNT_W-1:0]     hit_count;
        logic                 moved_to_front;
        logic                 evicted;
        logic [31:0]          evicted_key;
        logic [OCC_OUT_W-1:0] occupancy;
    } result_t;

    // per-cell update controls
    typedef struct packed {
        logic clear;     // drop entry
        logic load;      // take key, count and valid from the feed
        logic upd_cnt;   // rewrite count in place
    } cell_ctl_t;

endpackage

// ----- design/tmtf_cell.sv -----
// One entry of the ordered key buffer: key, hit counter, valid, key compare
module tmtf_cell #(
    parameter int KEY_WIDTH = 32
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  tmtf_pkg::cell_ctl_t          ctl,
    input  logic [KEY_WIDTH-1:0]         lookup_key,
    input  logic                         feed_valid,
    input  logic [KEY_WIDTH-1:0]         feed_key,
    input  logic [tmtf_pkg::CNT_W-1:0]   feed_count,
    input  logic [tmtf_pkg::CNT_W-1:0]   new_count,
    output logic                         valid,
    output logic [KEY_WIDTH-1:0]         key,
    output logic [tmtf_pkg::CNT_W-1:0]   count,
    output logic                         match
);
    import tmtf_pkg::*;

    logic                 valid_reg;
    logic [KEY_WIDTH-1:0] key_reg;
    logic [CNT_W-1:0]     count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            count_reg <= '0;
        end
        else if (ctl.clear)
        begin
            valid_reg <= 1'b0;
            count_reg <= '0;
        end
        else if (ctl.load)
        begin
            valid_reg <= feed_valid;
            count_reg <= feed_count;
        end
        else if (ctl.upd_cnt)
        begin
            count_reg <= new_count;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            key_reg <= feed_key;
        end
    end

    assign valid = valid_reg;
    assign key   = key_reg;
    assign count = count_reg;
    assign match = valid_reg && (key_reg == lookup_key);

endmodule

// ----- design/threshold_move_to_front_cache.sv -----
// Top level: row of cache cells, shift control, config registers, result register
//
//  channel  | signals                          | handshake
//  ---------+----------------------------------+-----------------------------
//  command  | cmd (func, address_key)          | start && !busy
//  result   | result (hit .. occupancy)        | done, one cycle, no stall
//  config   | cfg_index, cfg_data              | cfg_we, taken at once
//
// Every command is taken as it arrives: all cells compare in parallel and the
// row shifts by one place in the same edge, so a command per cycle is accepted.
// The result appears on the cycle after acceptance, with done high for one cycle.
// Reset empties the row; length_limit resets to 16, count_threshold to 1.
// busy stays low; the receiver cannot stall results.
module threshold_move_to_front_cache #(
    parameter int DEPTH     = 16,
    parameter int KEY_WIDTH = 32
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  tmtf_pkg::cmd_t              cmd,
    output logic                        done,
    output tmtf_pkg::result_t           result,
    input  logic                        cfg_we,
    input  tmtf_pkg::cfg_index_t        cfg_index,
    input  logic [tmtf_pkg::CFG_W-1:0]  cfg_data
);
    import tmtf_pkg::*;

    localparam int OCC_W = $clog2(DEPTH + 1);
    localparam int CMP_W = (OCC_W > LIMIT_W) ? OCC_W : LIMIT_W;

    logic [LIMIT_W-1:0]   length_limit_reg;
    logic [CNT_W-1:0]     count_threshold_reg;
    logic [OCC_W-1:0]     occ_reg;
    logic [OCC_W-1:0]     occ_next;
    logic                 done_reg;
    result_t              result_reg;
    result_t              result_next;

    logic [KEY_WIDTH-1:0] in_key;
    logic                 accept;
    logic                 do_access;
    logic                 do_clear;

    logic [DEPTH-1:0]     cell_valid;
    logic [DEPTH-1:0]     cell_match;
    logic [DEPTH-1:0]     at_or_before;   // cell index <= hit position
    logic [DEPTH-1:0]     in_shift_span;  // cell index <= occupancy after eviction
    logic [DEPTH-1:0]     is_tail;
    logic [KEY_WIDTH-1:0] cell_key   [DEPTH];
    logic [CNT_W-1:0]     cell_count [DEPTH];
    cell_ctl_t            cell_ctl   [DEPTH];

    logic                 any_hit;
    logic [CNT_W-1:0]     hit_cnt_cur;
    logic [CNT_W-1:0]     hit_cnt_inc;
    logic [KEY_WIDTH-1:0] tail_key;
    logic                 move;
    logic                 miss;
    logic                 evict;
    logic [CMP_W-1:0]     lim_raw;
    logic [CMP_W-1:0]     lim_eff;
    logic [CMP_W-1:0]     occ_ext;
    logic [OCC_W-1:0]     occ_span;

    assign busy      = 1'b0;
    assign accept    = start && !busy;
    assign do_access = accept && (cmd.func == FUNC_ACCESS);
    assign do_clear  = accept && (cmd.func == FUNC_CLEAR);
    assign in_key    = KEY_WIDTH'(cmd.address_key);

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            length_limit_reg    <= LIMIT_W'(16);
            count_threshold_reg <= CNT_ONE;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_LENGTH_LIMIT:    length_limit_reg    <= cfg_data[LIMIT_W-1:0];
                CFG_COUNT_THRESHOLD: count_threshold_reg <= cfg_data[CNT_W-1:0];
                default:             ;
            endcase
        end
    end

    // hit lookup and tail detection across the row
    always_comb
    begin
        any_hit     = 1'b0;
        hit_cnt_cur = '0;
        tail_key    = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            any_hit     = any_hit | cell_match[i];
            hit_cnt_cur = hit_cnt_cur | (cell_count[i] & {CNT_W{cell_match[i]}});
            tail_key    = tail_key | (cell_key[i] & {KEY_WIDTH{is_tail[i]}});
        end
    end

    assign hit_cnt_inc = (hit_cnt_cur == CNT_MAX) ? CNT_MAX : hit_cnt_cur + CNT_ONE;
    assign move = any_hit && (hit_cnt_inc > count_threshold_reg) && !cell_match[0];
    assign miss = !any_hit;

    assign lim_raw = CMP_W'(length_limit_reg);
    assign occ_ext = CMP_W'(occ_reg);
    always_comb
    begin
        if (lim_raw == '0)
            lim_eff = CMP_W'(1);
        else if (lim_raw > CMP_W'(DEPTH))
            lim_eff = CMP_W'(DEPTH);
        else
            lim_eff = lim_raw;
    end

    assign evict    = miss && (occ_ext >= lim_eff) && (occ_reg != '0);
    assign occ_span = evict ? occ_reg - OCC_W'(1) : occ_reg;

    always_comb
    begin
        if (do_clear)
            occ_next = '0;
        else if (do_access && miss && !evict)
            occ_next = occ_reg + OCC_W'(1);
        else
            occ_next = occ_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            occ_reg <= '0;
        else
            occ_reg <= occ_next;
    end

    // row of cells; each loads from its front neighbor when the row shifts, the front cell from the command
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic                 feed_valid;
        logic [KEY_WIDTH-1:0] feed_key;
        logic [CNT_W-1:0]     feed_count;

        assign at_or_before[i]  = |cell_match[DEPTH-1:i];
        assign in_shift_span[i] = (OCC_W'(i) <= occ_span);

        if (i == DEPTH - 1)
        begin : g_last
            assign is_tail[i] = cell_valid[i];
        end
        else
        begin : g_inner
            assign is_tail[i] = cell_valid[i] && !cell_valid[i+1];
        end

        if (i == 0)
        begin : g_front
            assign feed_valid = 1'b1;
            assign feed_key   = in_key;
            assign feed_count = miss ? CNT_ONE : hit_cnt_inc;
            assign cell_ctl[i].load = do_access && (miss || move);
        end
        else
        begin : g_rest
            assign feed_valid = cell_valid[i-1];
            assign feed_key   = cell_key[i-1];
            assign feed_count = cell_count[i-1];
            assign cell_ctl[i].load = do_access &&
                ((move && at_or_before[i]) || (miss && in_shift_span[i]));
        end

        assign cell_ctl[i].clear   = do_clear;
        assign cell_ctl[i].upd_cnt = do_access && any_hit && !move && cell_match[i];

        tmtf_cell #(
            .KEY_WIDTH(KEY_WIDTH)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctl        (cell_ctl[i]),
            .lookup_key (in_key),
            .feed_valid (feed_valid),
            .feed_key   (feed_key),
            .feed_count (feed_count),
            .new_count  (hit_cnt_inc),
            .valid      (cell_valid[i]),
            .key        (cell_key[i]),
            .count      (cell_count[i]),
            .match      (cell_match[i])
        );
    end

    // result register
    always_comb
    begin
        result_next = '0;
        if (cmd.func == FUNC_ACCESS)
        begin
            result_next.hit            = any_hit;
            result_next.hit_count      = miss ? CNT_ONE : hit_cnt_inc;
            result_next.moved_to_front = move;
            result_next.evicted        = evict;
            result_next.evicted_key    = evict ? 32'(tail_key) : 32'd0;
            result_next.occupancy      = OCC_OUT_W'(occ_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= accept;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

// ----- design/tmtf_checker.sv -----
// Port-level checks for the threshold move-to-front cache, bound to the top level
`include "assert_macros.svh"

module tmtf_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                start,
    input logic                busy,
    input logic                done,
    input tmtf_pkg::result_t   result
);

    `ASSERT_NEXT(a_done_follows, start && !busy, done, "accepted transaction gave no result")
    `ASSERT_NEXT(a_no_stray_done, !(start && !busy), !done, "result without a transaction")
    `ASSERT_IMPL(a_move_needs_hit, done && result.moved_to_front, result.hit, "move without hit")
    `ASSERT_IMPL(a_evict_on_miss, done && result.evicted, !result.hit, "eviction on a hit")
    `ASSERT_IMPL(a_access_nonempty, done && |result.hit_count, |result.occupancy, "no entries")

endmodule

bind threshold_move_to_front_cache tmtf_checker u_tmtf_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);
